// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define RBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds through reset
`define RBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rbb_pkg.sv =====
// types, constants and helpers of the rgb 3x3 box blur
package rbb_pkg;

    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 4;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int POS_W       = 9;
    localparam int WIN_N       = 9;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SH    = 16;
    localparam int MAX_WIDTH_DEF = 256;

    localparam logic [CFG_W-1:0]   SIZE_AT_RESET = 9'd256;
    // reciprocals scaled by 2^16, exact for sums up to 9 * 255
    localparam logic [RECIP_W-1:0] RECIP6 = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP9 = 14'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 4'd0,
        CFG_FRAME_HEIGHT = 4'd1
    } t_cfg_reg;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } t_div;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic emit;
        logic top_ok;
        logic bottom_ok;
        logic row_end;
        logic wide;
        logic flush;
    } t_ctl;

    // which window cells a lane adds up
    typedef struct packed {
        logic [2:0] row_en;
        logic       col0_en;
    } t_lane_ctl;

    // truncated mean from a neighbourhood sum
    function automatic logic [CH_W-1:0] div_sum(input logic [SUM_W-1:0] sum,
                                                input t_div div);
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [CH_W-1:0]          quot;
        prod = '0;
        unique case (div)
            DIV4: quot = sum[2 +: CH_W];
            DIV6: begin
                prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP6);
                quot = prod[RECIP_SH +: CH_W];
            end
            DIV9: begin
                prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP9);
                quot = prod[RECIP_SH +: CH_W];
            end
            default: quot = '0;
        endcase
        return quot;
    endfunction

endpackage

// ===== src/rbb_if.sv =====
// handshake channels of the box blur: pixel in, pixel out, configuration
interface rbb_pix_in_if;
    import rbb_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;

    modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface rbb_pix_out_if;
    import rbb_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic              run_last;
    logic              frame_last;

    modport source (output valid, red_out, green_out, blue_out, run_last, frame_last,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, run_last, frame_last,
                    output ready);
endinterface

interface rbb_cfg_if;
    import rbb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rgb_box_blur_3x3.sv =====
// top level of the streaming rgb 3x3 box blur
// a beat passes the input, window, sum and output registers before its result shows
// throughput: one pixel beat per cycle; the second result of a row end takes the
//   slot of the next row's first pixel, which gives none, so only output stalls hold it
// results trail the input by one row and one pixel; a flush row ends the frame
// reset clears positions, window, pipeline valids and sets both sizes to 256
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rbb_pix_in_if.sink          i_pix,
    rbb_pix_out_if.source       o_pix,
    rbb_cfg_if.sink             i_cfg
);
    import rbb_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // configuration and position state
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;

    // pipeline registers
    logic             r_s1_vld;
    t_ctl             r_s1_ctl;
    logic [PIX_W-1:0] r_s1_px;
    logic [AW-1:0]    r_s1_addr;
    logic [WIN_N-1:0][PIX_W-1:0] r_win;
    logic             r_s2_vld;
    t_ctl             r_s2_ctl;
    logic             r_s3_vld;
    logic             r_s3_two;
    logic             r_s3_flush;
    t_div             r_s3_div_a;
    t_div             r_s3_div_b;
    logic             r_s4_vld;
    logic             r_s4_phase;
    logic             r_s4_two;
    logic             r_s4_flush;
    logic [2:0][CH_W-1:0] r_s4_quot_a;
    logic [2:0][CH_W-1:0] r_s4_quot_b;

    // combinational
    logic [POS_W-1:0] w_used;
    logic [POS_W-1:0] h_used;
    logic [POS_W-1:0] col_c;
    logic [POS_W-1:0] row_c;
    logic [POS_W-1:0] n_col;
    logic [POS_W-1:0] n_row;
    logic             flush_row;
    logic [PIX_W-1:0] n_px;
    t_ctl             n_ctl;
    logic             cfg_wr;
    logic             accept;
    logic             s1_adv, s2_adv, s3_adv;
    logic             s1_rdy, s2_rdy, s3_rdy, s4_rdy;
    logic             o_hs, s4_done;
    logic [2*PIX_W-1:0] rd_data;
    logic             rows3;
    t_lane_ctl        lane_ctl;
    logic [2:0][CH_W-1:0] quot_a;
    logic [2:0][CH_W-1:0] quot_b;

    // handshake chain, output side back to input
    assign o_hs    = o_pix.valid & o_pix.ready;
    assign s4_done = o_hs & (~r_s4_two | r_s4_phase);
    assign s4_rdy  = ~r_s4_vld | s4_done;
    assign s3_adv  = r_s3_vld & s4_rdy;
    assign s3_rdy  = ~r_s3_vld | s4_rdy;
    assign s2_adv  = r_s2_vld & s3_rdy;
    assign s2_rdy  = ~r_s2_vld | s3_rdy;
    assign s1_adv  = r_s1_vld & s2_rdy;
    assign s1_rdy  = ~r_s1_vld | s2_rdy;
    assign accept  = i_pix.valid & s1_rdy;
    assign i_pix.ready = s1_rdy;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr  = i_cfg.valid;

    // frame size in use and position of this beat
    always_comb begin
        if (r_frame_width < POS_W'(2)) begin
            w_used = POS_W'(2);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_used = POS_W'(MAX_WIDTH);
        end else begin
            w_used = r_frame_width;
        end
        h_used    = (r_frame_height < POS_W'(2)) ? POS_W'(2) : r_frame_height;
        col_c     = (r_col >= w_used) ? '0 : r_col;
        row_c     = (r_row > h_used) ? '0 : r_row;
        flush_row = (row_c >= h_used);
        n_px      = (!flush_row && t_req'(i_pix.req_type) == REQ_PIXEL)
                  ? {i_pix.red_in, i_pix.green_in, i_pix.blue_in} : '0;
        n_ctl.emit      = (row_c != '0) && (col_c != '0);
        n_ctl.top_ok    = (row_c >= POS_W'(2));
        n_ctl.bottom_ok = ~flush_row;
        n_ctl.row_end   = (col_c == w_used - POS_W'(1));
        n_ctl.wide      = (col_c >= POS_W'(2));
        n_ctl.flush     = flush_row;
        if (col_c + POS_W'(1) >= w_used) begin
            n_col = '0;
            n_row = flush_row ? '0 : row_c + POS_W'(1);
        end else begin
            n_col = col_c + POS_W'(1);
            n_row = row_c;
        end
    end

    // line stores: older row in the upper half, previous row in the lower
    rbb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (2 * PIX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(col_c)),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({rd_data[PIX_W-1:0], r_s1_px})
    );

    // control state, positions and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= SIZE_AT_RESET;
            r_frame_height <= SIZE_AT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_win          <= '0;
            r_s1_vld       <= 1'b0;
            r_s2_vld       <= 1'b0;
            r_s3_vld       <= 1'b0;
        end else begin
            // stage 1: beat taken, store read issued
            if (accept) begin
                r_s1_vld <= 1'b1;
                r_col    <= n_col;
                r_row    <= n_row;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            // stage 2: window shift
            if (s1_adv) begin
                r_s2_vld <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= rd_data[2*PIX_W-1:PIX_W];
                r_win[5] <= rd_data[PIX_W-1:0];
                r_win[8] <= r_s1_px;
            end else if (s2_adv) begin
                r_s2_vld <= 1'b0;
            end
            // stage 3: sums, valid only for beats that give results
            if (s2_adv) begin
                r_s3_vld <= r_s2_ctl.emit;
            end else if (s3_adv) begin
                r_s3_vld <= 1'b0;
            end
            // a write to either size register restarts the frame
            if (cfg_wr) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg.data;
                        r_col         <= '0;
                        r_row         <= '0;
                        r_win         <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg.data;
                        r_col          <= '0;
                        r_row          <= '0;
                        r_win          <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload of stages 1 to 3
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl  <= n_ctl;
            r_s1_px   <= n_px;
            r_s1_addr <= AW'(col_c);
        end
        if (s1_adv) begin
            r_s2_ctl <= r_s1_ctl;
        end
        if (s2_adv) begin
            r_s3_two   <= r_s2_ctl.row_end;
            r_s3_flush <= r_s2_ctl.flush;
            if (r_s2_ctl.wide) begin
                r_s3_div_a <= rows3 ? DIV9 : DIV6;
            end else begin
                r_s3_div_a <= rows3 ? DIV6 : DIV4;
            end
            r_s3_div_b <= rows3 ? DIV6 : DIV4;
        end
    end

    assign rows3            = r_s2_ctl.top_ok & r_s2_ctl.bottom_ok;
    assign lane_ctl.row_en  = {r_s2_ctl.bottom_ok, 1'b1, r_s2_ctl.top_ok};
    assign lane_ctl.col0_en = r_s2_ctl.wide;

    // one lane per colour channel, red first
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [WIN_N-1:0][CH_W-1:0] ch_win;
        for (genvar k = 0; k < WIN_N; k++) begin : g_cell
            assign ch_win[k] = r_win[k][PIX_W-1-CH_W*ch -: CH_W];
        end
        rbb_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (s2_adv),
            .i_win    (ch_win),
            .i_ctl    (lane_ctl),
            .i_div_a  (r_s3_div_a),
            .i_div_b  (r_s3_div_b),
            .o_quot_a (quot_a[ch]),
            .o_quot_b (quot_b[ch])
        );
    end

    // stage 4: output register, one or two beats per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld   <= 1'b0;
            r_s4_phase <= 1'b0;
        end else if (s3_adv) begin
            r_s4_vld   <= 1'b1;
            r_s4_phase <= 1'b0;
        end else if (s4_done) begin
            r_s4_vld   <= 1'b0;
        end else if (o_hs) begin
            r_s4_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_s4_two    <= r_s3_two;
            r_s4_flush  <= r_s3_flush;
            r_s4_quot_a <= quot_a;
            r_s4_quot_b <= quot_b;
        end
    end

    // merge the lanes into the output beat
    assign o_pix.valid      = r_s4_vld;
    assign o_pix.red_out    = r_s4_phase ? r_s4_quot_b[0] : r_s4_quot_a[0];
    assign o_pix.green_out  = r_s4_phase ? r_s4_quot_b[1] : r_s4_quot_a[1];
    assign o_pix.blue_out   = r_s4_phase ? r_s4_quot_b[2] : r_s4_quot_a[2];
    assign o_pix.run_last   = r_s4_phase | ~r_s4_two;
    assign o_pix.frame_last = r_s4_phase & r_s4_flush;
endmodule

// ===== src/rbb_line_store.sv =====
// line store ram: one write port, one registered read port
module rbb_line_store #(
    parameter int DEPTH = rbb_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 2 * rbb_pkg::PIX_W
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/rbb_lane.sv =====
// one colour lane: masked window sums, then division by the cell count
module rbb_lane (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [rbb_pkg::WIN_N-1:0][rbb_pkg::CH_W-1:0] i_win,
    input  rbb_pkg::t_lane_ctl                  i_ctl,
    input  rbb_pkg::t_div                       i_div_a,
    input  rbb_pkg::t_div                       i_div_b,
    output logic [rbb_pkg::CH_W-1:0]            o_quot_a,
    output logic [rbb_pkg::CH_W-1:0]            o_quot_b
);
    import rbb_pkg::*;

    logic [SUM_W-1:0] n_sum_a;
    logic [SUM_W-1:0] n_sum_b;
    logic [SUM_W-1:0] r_sum_a;
    logic [SUM_W-1:0] r_sum_b;

    // sums over the in-frame rows; column 0 only for the wide result
    always_comb begin
        logic [SUM_W-1:0] col0;
        col0   = '0;
        n_sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            n_sum_b = n_sum_b
                    + SUM_W'(i_win[k*3+1] & {CH_W{i_ctl.row_en[k]}})
                    + SUM_W'(i_win[k*3+2] & {CH_W{i_ctl.row_en[k]}});
            col0 = col0 + SUM_W'(i_win[k*3] & {CH_W{i_ctl.row_en[k] & i_ctl.col0_en}});
        end
        n_sum_a = n_sum_b + col0;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_quot_a = div_sum(r_sum_a, i_div_a);
    assign o_quot_b = div_sum(r_sum_b, i_div_b);
endmodule

// ===== src/rbb_checker.sv =====
// port-level checks of the box blur, bound to the top level
`include "assert_macros.svh"

module rbb_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    rbb_pix_in_if.sink     i_pix,
    rbb_pix_out_if.source  o_pix,
    rbb_cfg_if.sink        i_cfg
);
    // a stalled output beat keeps its payload
    `RBB_ASSERT(a_out_hold, i_clk, i_rst_n, o_pix.valid && !o_pix.ready |=> o_pix.valid && $stable(o_pix.red_out) && $stable(o_pix.green_out) && $stable(o_pix.blue_out) && $stable(o_pix.run_last), "output beat changed while stalled")

    // the first result of a row-end pixel is followed at once by its second
    `RBB_ASSERT(a_pair, i_clk, i_rst_n, o_pix.valid && o_pix.ready && !o_pix.run_last |=> o_pix.valid && o_pix.run_last, "second result of a row end missing")

    // frame end only on the closing beat of a pixel
    `RBB_ASSERT(a_frame_last, i_clk, i_rst_n, o_pix.valid && o_pix.frame_last |-> o_pix.run_last && i_cfg.ready, "frame end on an inner beat")

    // nothing comes out straight after reset
    `RBB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_pix.valid, "output valid after reset")
endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pix   (i_pix),
    .o_pix   (o_pix),
    .i_cfg   (i_cfg)
);
